FILE: hw/rtl/chebyshev_series_eval_assert.svh
// assertion macros for the chebyshev series evaluator
// expects clk and rst in the scope of the file that includes it
`ifndef CHEBYSHEV_SERIES_EVAL_ASSERT_SVH
`define CHEBYSHEV_SERIES_EVAL_ASSERT_SVH

// same-cycle implication
`define CSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cse_pkg.sv
// shared widths, codes and clipping helpers for the chebyshev series evaluator
// no dependencies
package cse_pkg;

  localparam int DATA_W    = 32;
  localparam int DEG_W     = 7;
  localparam int IDX_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 64;
  localparam int ACC_W     = 64;

  localparam logic OP_EVAL = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 2'd2;

  // 1.0 in q8.24
  localparam logic signed [DATA_W-1:0] T0_ONE = 32'sh0100_0000;

  localparam logic signed [PROD_W-1:0] LIM_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] LIM_LO = -64'sh0000_0000_8000_0000;

  function automatic logic signed [DATA_W-1:0] clip32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > LIM_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < LIM_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic clipped(input logic signed [PROD_W-1:0] v);
    return (v > LIM_HI) || (v < LIM_LO);
  endfunction

endpackage

FILE: hw/rtl/chebyshev_series_eval.sv
// an evaluate word gives one result and a load word gives none; no new command is taken
// until an evaluate has loaded its result word (cmd_stall is high outside idle), since the
// single shared multiplier scales the sample and is then used twice for each term from T1 up
// to the one below the highest (x*Tj for the recurrence, cj*Tj for the sum)
// reset: synchronous, active high; config returns to scale 1.0, offset 0, degree 0;
// the coefficient table is not cleared and holds garbage until loaded
`include "chebyshev_series_eval_assert.svh"

module chebyshev_series_eval
  import cse_pkg::*;
#(
  parameter int MAX_COEFFS = 128
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration writes
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  // command words
  input  logic                     cmd_valid,
  output logic                     cmd_stall,
  input  logic                     opcode,
  input  logic [IDX_W-1:0]         coef_index,
  input  logic signed [DATA_W-1:0] coef_value,
  input  logic signed [DATA_W-1:0] sample,
  // result words
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic signed [DATA_W-1:0] result,
  output logic                     saturated
);

  localparam int AW = $clog2(MAX_COEFFS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_X1,
    S_X2,
    S_N,
    S_C,
    S_A,
    S_FIN
  } state_t;

  state_t state;

  logic signed [DATA_W-1:0] scale_factor;
  logic signed [DATA_W-1:0] offset_value;
  logic [DEG_W-1:0]         degree;

  logic signed [DATA_W-1:0] sample_r;
  logic [DEG_W-1:0]         deg_r;
  logic [DEG_W-1:0]         j;
  logic [DEG_W-1:0]         j_next;
  logic signed [DATA_W-1:0] x;
  logic signed [DATA_W-1:0] tj;
  logic signed [DATA_W-1:0] tp;
  logic signed [ACC_W-1:0]  acc;
  logic                     acc_pend;
  logic                     sat_r;

  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [PROD_W-1:0] p;

  logic                     mem_we;
  logic [DATA_W-1:0]        rdata;
  logic [DEG_W-1:0]         deg_eff;

  logic signed [PROD_W-1:0] x_sum;
  logic signed [PROD_W-1:0] tn_sum;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  c0_half;
  logic signed [ACC_W-1:0]  res_sum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= 32'sd65536;
      offset_value <= '0;
      degree       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE:  scale_factor <= cfg_data;
        REG_OFFSET: offset_value <= cfg_data;
        REG_DEGREE: degree       <= cfg_data[DEG_W-1:0];
        default:    ;
      endcase
    end
  end

  assign cmd_stall = (state != S_IDLE);
  assign mem_we    = (state == S_IDLE) && cmd_valid && (opcode == OP_LOAD) &&
                     (int'(coef_index) < MAX_COEFFS);
  assign deg_eff   = (int'(degree) > MAX_COEFFS - 1) ? DEG_W'(MAX_COEFFS - 1) : degree;

  // read address follows the term index of the coming cycle
  always_comb begin
    j_next = j;
    unique case (state)
      S_IDLE:  j_next = '0;
      S_X1:    j_next = DEG_W'(1);
      S_C:     if (j < deg_r) j_next = j + DEG_W'(1);
      default: ;
    endcase
  end

  cse_coef_mem #(
    .DEPTH (MAX_COEFFS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(coef_index)),
    .wdata (coef_value),
    .raddr (AW'(j_next)),
    .rdata (rdata)
  );

  always_comb begin
    unique case (state)
      S_X1: begin
        mul_a = sample_r;
        mul_b = scale_factor;
      end
      S_C: begin
        mul_a = $signed(rdata);
        mul_b = tj;
      end
      default: begin
        mul_a = x;
        mul_b = tj;
      end
    endcase
  end

  cse_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  assign x_sum   = (p >>> 8) + $signed({{24{offset_value[DATA_W-1]}}, offset_value, 8'd0});
  assign tn_sum  = (p >>> 23) - $signed({{32{tp[DATA_W-1]}}, tp});
  assign term    = p >>> 24;
  assign c0_half = $signed({{33{rdata[DATA_W-1]}}, rdata[DATA_W-1:1]});
  assign res_sum = acc >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      acc_pend  <= 1'b0;
    end else begin
      // the final state loads the next word itself when the held one drains
      if (rsp_valid && !rsp_stall && (state != S_FIN)) begin
        rsp_valid <= 1'b0;
      end
      j        <= j_next;
      acc_pend <= (state == S_C);
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && (opcode == OP_EVAL)) begin
            sample_r <= sample;
            deg_r    <= deg_eff;
            sat_r    <= 1'b0;
            state    <= S_X1;
          end
        end
        S_X1: begin
          acc <= c0_half;
          if (deg_r == '0) begin
            state <= S_FIN;
          end else begin
            state <= S_X2;
          end
        end
        S_X2: begin
          x     <= clip32(x_sum);
          tj    <= clip32(x_sum);
          tp    <= T0_ONE;
          sat_r <= sat_r | clipped(x_sum);
          state <= (deg_r > DEG_W'(1)) ? S_N : S_C;
        end
        S_N: begin
          if (acc_pend) begin
            acc <= acc + term;
          end
          state <= S_C;
        end
        S_C: begin
          if (acc_pend) begin
            acc <= acc + term;
          end
          // product in flight is x*Tj whenever another term follows
          if (j < deg_r) begin
            tp    <= tj;
            tj    <= clip32(tn_sum);
            sat_r <= sat_r | clipped(tn_sum);
            state <= (j + DEG_W'(1) < deg_r) ? S_N : S_C;
          end else begin
            state <= S_A;
          end
        end
        S_A: begin
          acc   <= acc + term;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            result    <= clip32(res_sum);
            saturated <= sat_r | clipped(res_sum);
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CSE_ASSERT_IMP(a_recur_index, state == S_N, j < deg_r, "recurrence step past degree")
  `CSE_ASSERT_NXT(a_load_quiet, cmd_valid && !cmd_stall && opcode == OP_LOAD, !$rose(rsp_valid), "load word produced a result")
  `CSE_ASSERT_IMP(a_deg0_clean, state == S_FIN && deg_r == '0, !sat_r, "clip flag set at degree zero")

endmodule

FILE: hw/rtl/cse_coef_mem.sv
// coefficient table: one write port, one read port with registered data
// uses cse_pkg for the data width
module cse_coef_mem
  import cse_pkg::*;
#(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/cse_mul.sv
// shared signed 32x32 multiplier with registered 64-bit product
// uses cse_pkg for widths
module cse_mul
  import cse_pkg::*;
(
  input  logic                     clk,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
